[rtl/mg3_pkg.sv]
// shared constants, types and codes of the mahalanobis corner gate
package mg3_pkg;

  // fixed-point format and angle constants
  localparam int FRAC_BITS = 16;
  localparam logic [63:0] PI_Q32 = 64'd13493037705;
  localparam logic [63:0] PI_FIX =
    (PI_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
  localparam logic [63:0] TWO_PI_FIX = 64'd2 * PI_FIX;
  // multiple of two pi that lifts any 33-bit difference above zero
  localparam logic [63:0] WRAP_OFFS =
    ((64'd1 << 32) + TWO_PI_FIX - 64'd1) / TWO_PI_FIX * TWO_PI_FIX;
  localparam logic [63:0] WRAP_BIAS = WRAP_OFFS + PI_FIX;
  // reciprocal of two pi for the wrap quotient estimate
  localparam int RECIP_SHIFT = 36;
  localparam logic [63:0] WRAP_RECIP = (64'd1 << RECIP_SHIFT) / TWO_PI_FIX;

  // stream widths
  localparam int S_DATA_W = 320;
  localparam int M_DATA_W = 40;

  // queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = 2;

  // commands carried in tuser
  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TEST = 1'b1
  } cmd_t;

  // register index taken from paddr[2]
  typedef enum logic {
    REG_APERTURE_THR = 1'b0,
    REG_GATE_LIMIT   = 1'b1
  } cfg_reg_t;

  // one test word queued for the arithmetic back end
  typedef struct packed {
    logic [32:0] dx;
    logic [32:0] dy;
    logic [32:0] dt_raw;
    logic [32:0] da_raw;
    logic [32:0] ma;
    logic [32:0] mb;
    logic [32:0] mc;
    logic [32:0] md;
    logic [32:0] me;
    logic [32:0] mf;
  } mg3_item_t;

  // result flags travelling with the divider
  typedef struct packed {
    logic sing;
    logic neg;
    logic sat;
    logic ap_ok;
  } mg3_flags_t;

endpackage

[rtl/mg3_front.sv]
// front end: takes words, holds the landmark, forms differences and sums
module mg3_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // pos_x, pos_y, heading, aperture, cov_xx, cov_xy, cov_xt, cov_yy, cov_yt,
  // cov_tt, is_corner, zero fill
  input  logic [mg3_pkg::S_DATA_W-1:0]    s_tdata,
  // cmd
  input  logic [0:0]                      s_tuser,
  output logic                            push,
  output mg3_pkg::mg3_item_t              push_data,
  input  logic                            fifo_full
);
  import mg3_pkg::*;

  logic [31:0] pos_x, pos_y, heading, aperture, cov_xy, cov_xt, cov_yt;
  logic [30:0] cov_xx, cov_yy, cov_tt;
  logic        is_corner, accept;
  cmd_t        cmd;

  logic [31:0] hx, hy, hh, ha, hxy, hxt, hyt;
  logic [30:0] hxx, hyy, htt;
  logic        held_corner;

  // field unpacking
  assign pos_x     = s_tdata[31:0];
  assign pos_y     = s_tdata[63:32];
  assign heading   = s_tdata[95:64];
  assign aperture  = s_tdata[127:96];
  assign cov_xx    = s_tdata[158:128];
  assign cov_xy    = s_tdata[190:159];
  assign cov_xt    = s_tdata[222:191];
  assign cov_yy    = s_tdata[253:223];
  assign cov_yt    = s_tdata[285:254];
  assign cov_tt    = s_tdata[316:286];
  assign is_corner = s_tdata[317];
  assign cmd       = cmd_t'(s_tuser[0]);

  // handshake and classification
  assign s_tready = !fifo_full;
  assign accept   = s_tvalid && s_tready;
  assign push     = accept && (cmd == CMD_TEST) && held_corner;

  // pose differences and covariance sums
  always_comb begin
    push_data.dx     = {pos_x[31], pos_x} - {hx[31], hx};
    push_data.dy     = {pos_y[31], pos_y} - {hy[31], hy};
    push_data.dt_raw = {heading[31], heading} - {hh[31], hh};
    push_data.da_raw = {aperture[31], aperture} - {ha[31], ha};
    push_data.ma     = {2'b00, cov_xx} + {2'b00, hxx};
    push_data.mb     = {cov_xy[31], cov_xy} + {hxy[31], hxy};
    push_data.mc     = {cov_xt[31], cov_xt} + {hxt[31], hxt};
    push_data.md     = {2'b00, cov_yy} + {2'b00, hyy};
    push_data.me     = {cov_yt[31], cov_yt} + {hyt[31], hyt};
    push_data.mf     = {2'b00, cov_tt} + {2'b00, htt};
  end

  // held landmark flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_corner <= 1'b0;
    end else if (accept && (cmd == CMD_LOAD)) begin
      held_corner <= is_corner;
    end
  end

  // held landmark values
  always_ff @(posedge clk) begin
    if (rst) begin
      hx  <= '0;
      hy  <= '0;
      hh  <= '0;
      ha  <= '0;
      hxx <= '0;
      hxy <= '0;
      hxt <= '0;
      hyy <= '0;
      hyt <= '0;
      htt <= '0;
    end else if (accept && (cmd == CMD_LOAD)) begin
      hx  <= pos_x;
      hy  <= pos_y;
      hh  <= heading;
      ha  <= aperture;
      hxx <= cov_xx;
      hxy <= cov_xy;
      hxt <= cov_xt;
      hyy <= cov_yy;
      hyt <= cov_yt;
      htt <= cov_tt;
    end
  end

endmodule

[rtl/mg3_fifo.sv]
// short queue that decouples the front end from the arithmetic back end
module mg3_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mg3_pkg::mg3_item_t push_data,
  output logic               full,
  input  logic               pop,
  output mg3_pkg::mg3_item_t pop_data,
  output logic               not_empty
);
  import mg3_pkg::*;

  mg3_item_t          mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [FIFO_AW:0]   count;

  assign full      = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/mg3_back.sv]
// back end: angle wrap, 3x3 adjugate, quadratic form and pipelined divide
module mg3_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  mg3_pkg::mg3_item_t           in_data,
  output logic                         in_pop,
  input  logic [30:0]                  aperture_threshold,
  input  logic [31:0]                  gate_limit,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // dist_sq, aperture_ok, in_gate, singular, zero fill
  output logic [mg3_pkg::M_DATA_W-1:0] m_tdata
);
  import mg3_pkg::*;

  localparam int NPIPE = 9 + 32;

  function automatic logic signed [32:0] wrap_fin(input logic [35:0] u,
                                                  input logic [35:0] qd);
    logic [35:0] r;
    r = u - qd;
    if (r >= TWO_PI_FIX[35:0]) begin
      r = r - TWO_PI_FIX[35:0];
    end
    return $signed({1'b0, r[31:0]}) - $signed(PI_FIX[32:0]);
  endfunction

  logic             en;
  logic [NPIPE-1:0] vpipe;

  // stage 1
  logic [35:0]        ua_c, ut_c;
  logic [71:0]        s1_ua_prod, s1_ut_prod;
  logic [35:0]        s1_ua, s1_ut;
  logic signed [65:0] s1_p [12];
  logic signed [32:0] ma, mb, mc, md, me, mf;
  logic signed [32:0] s1_a, s1_b, s1_c, s1_dx, s1_dy;
  // stage 2
  logic signed [66:0] s2_cof [6];
  logic [35:0]        s2_qa, s2_qt, s2_ua, s2_ut;
  logic signed [32:0] s2_a, s2_b, s2_c, s2_dx, s2_dy;
  // stage 3
  logic signed [66:0] s3_cof [6];
  logic [35:0]        s3_qda, s3_qdt, s3_ua, s3_ut;
  logic signed [32:0] s3_a, s3_b, s3_c, s3_dx, s3_dy;
  // stage 4
  logic signed [66:0] s4_cof [6];
  logic signed [32:0] s4_m [3];
  logic signed [32:0] s4_d [3];
  logic signed [32:0] s4_da;
  // stage 5
  logic signed [66:0] cf [3][3];
  logic signed [67:0] wlo_c [3][3];
  logic signed [65:0] whi_c [3][3];
  logic signed [67:0] dlo_c [3];
  logic signed [65:0] dhi_c [3];
  logic [32:0]        ada;
  logic signed [67:0] s5_wlo [3][3];
  logic signed [65:0] s5_whi [3][3];
  logic signed [67:0] s5_dlo [3];
  logic signed [65:0] s5_dhi [3];
  logic signed [32:0] s5_d [3];
  logic               s5_ap_ok;
  // stage 6
  logic signed [101:0] w_c [3];
  logic signed [103:0] det_c;
  logic signed [101:0] s6_w [3];
  logic signed [103:0] s6_det;
  logic signed [32:0]  s6_d [3];
  logic                s6_ap_ok;
  // stage 7
  logic signed [67:0]  s7_n0 [3];
  logic signed [67:0]  s7_n1 [3];
  logic signed [66:0]  s7_n2 [3];
  logic signed [103:0] s7_det;
  logic                s7_ap_ok;
  // stage 8
  logic signed [139:0] num_c;
  logic signed [139:0] s8_num;
  logic signed [103:0] s8_det;
  logic                s8_ap_ok;
  // divider chain, entry 0 is the setup stage
  logic [139:0]        dv_rem [0:32];
  logic [31:0]         dv_q   [0:32];
  logic [103:0]        dv_den [0:32];
  mg3_flags_t          dv_flg [0:32];
  // result
  mg3_flags_t          fin;
  logic [31:0]         dist_out;
  logic                gate;

  // pipeline advances when the output register is free or being taken
  assign en     = !m_tvalid || m_tready;
  assign in_pop = en && in_valid;

  // stage 1: wrap quotient estimate and cofactor products
  always_comb begin
    ma   = $signed(in_data.ma);
    mb   = $signed(in_data.mb);
    mc   = $signed(in_data.mc);
    md   = $signed(in_data.md);
    me   = $signed(in_data.me);
    mf   = $signed(in_data.mf);
    ua_c = {{3{in_data.da_raw[32]}}, in_data.da_raw} + WRAP_BIAS[35:0];
    ut_c = {{3{in_data.dt_raw[32]}}, in_data.dt_raw} + WRAP_BIAS[35:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ua      <= ua_c;
      s1_ut      <= ut_c;
      s1_ua_prod <= ua_c * WRAP_RECIP[35:0];
      s1_ut_prod <= ut_c * WRAP_RECIP[35:0];
      s1_p[0]    <= md * mf;
      s1_p[1]    <= me * me;
      s1_p[2]    <= mc * me;
      s1_p[3]    <= mb * mf;
      s1_p[4]    <= mb * me;
      s1_p[5]    <= mc * md;
      s1_p[6]    <= ma * mf;
      s1_p[7]    <= mc * mc;
      s1_p[8]    <= mb * mc;
      s1_p[9]    <= ma * me;
      s1_p[10]   <= ma * md;
      s1_p[11]   <= mb * mb;
      s1_a       <= ma;
      s1_b       <= mb;
      s1_c       <= mc;
      s1_dx      <= $signed(in_data.dx);
      s1_dy      <= $signed(in_data.dy);
    end
  end

  // stage 2: adjugate entries and wrap quotients
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        s2_cof[k] <= 67'(s1_p[2*k]) - 67'(s1_p[2*k+1]);
      end
      s2_qa <= s1_ua_prod[71:36];
      s2_qt <= s1_ut_prod[71:36];
      s2_ua <= s1_ua;
      s2_ut <= s1_ut;
      s2_a  <= s1_a;
      s2_b  <= s1_b;
      s2_c  <= s1_c;
      s2_dx <= s1_dx;
      s2_dy <= s1_dy;
    end
  end

  // stage 3: quotient times two pi
  always_ff @(posedge clk) begin
    if (en) begin
      s3_cof <= s2_cof;
      s3_qda <= s2_qa * TWO_PI_FIX[35:0];
      s3_qdt <= s2_qt * TWO_PI_FIX[35:0];
      s3_ua  <= s2_ua;
      s3_ut  <= s2_ut;
      s3_a   <= s2_a;
      s3_b   <= s2_b;
      s3_c   <= s2_c;
      s3_dx  <= s2_dx;
      s3_dy  <= s2_dy;
    end
  end

  // stage 4: remainder correction gives the wrapped angles
  always_ff @(posedge clk) begin
    if (en) begin
      s4_cof  <= s3_cof;
      s4_m[0] <= s3_a;
      s4_m[1] <= s3_b;
      s4_m[2] <= s3_c;
      s4_d[0] <= s3_dx;
      s4_d[1] <= s3_dy;
      s4_d[2] <= wrap_fin(s3_ut, s3_qdt);
      s4_da   <= wrap_fin(s3_ua, s3_qda);
    end
  end

  // stage 5: partial products of adjugate times difference, and of det
  always_comb begin
    cf[0][0] = s4_cof[0];
    cf[0][1] = s4_cof[1];
    cf[0][2] = s4_cof[2];
    cf[1][0] = s4_cof[1];
    cf[1][1] = s4_cof[3];
    cf[1][2] = s4_cof[4];
    cf[2][0] = s4_cof[2];
    cf[2][1] = s4_cof[4];
    cf[2][2] = s4_cof[5];
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        wlo_c[i][j] = s4_d[j] * $signed({1'b0, cf[i][j][33:0]});
        whi_c[i][j] = s4_d[j] * $signed(cf[i][j][66:34]);
      end
      dlo_c[i] = s4_m[i] * $signed({1'b0, cf[0][i][33:0]});
      dhi_c[i] = s4_m[i] * $signed(cf[0][i][66:34]);
    end
    ada = s4_da[32] ? 33'(-s4_da) : 33'(s4_da);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_wlo   <= wlo_c;
      s5_whi   <= whi_c;
      s5_dlo   <= dlo_c;
      s5_dhi   <= dhi_c;
      s5_d     <= s4_d;
      s5_ap_ok <= (ada < {2'b00, aperture_threshold});
    end
  end

  // stage 6: assemble adjugate times difference and the determinant
  always_comb begin
    det_c = '0;
    for (int i = 0; i < 3; i++) begin
      w_c[i] = '0;
      for (int j = 0; j < 3; j++) begin
        w_c[i] = w_c[i] + (102'(s5_whi[i][j]) <<< 34) + 102'(s5_wlo[i][j]);
      end
      det_c = det_c + (104'(s5_dhi[i]) <<< 34) + 104'(s5_dlo[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_w     <= w_c;
      s6_det   <= det_c;
      s6_d     <= s5_d;
      s6_ap_ok <= s5_ap_ok;
    end
  end

  // stage 7: difference times the three chunks of each row sum
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s7_n0[i] <= s6_d[i] * $signed({1'b0, s6_w[i][33:0]});
        s7_n1[i] <= s6_d[i] * $signed({1'b0, s6_w[i][67:34]});
        s7_n2[i] <= s6_d[i] * $signed(s6_w[i][101:68]);
      end
      s7_det   <= s6_det;
      s7_ap_ok <= s6_ap_ok;
    end
  end

  // stage 8: quadratic form
  always_comb begin
    num_c = '0;
    for (int i = 0; i < 3; i++) begin
      num_c = num_c + (140'(s7_n2[i]) <<< 68) + (140'(s7_n1[i]) <<< 34)
            + 140'(s7_n0[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_num   <= num_c;
      s8_det   <= s7_det;
      s8_ap_ok <= s7_ap_ok;
    end
  end

  // stage 9: divider setup, singular, negative and overflow checks
  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem[0]       <= s8_num;
      dv_q[0]         <= '0;
      dv_den[0]       <= s8_det;
      dv_flg[0].sing  <= s8_det[103] || (s8_det == '0);
      dv_flg[0].neg   <= s8_num[139];
      dv_flg[0].sat   <= (s8_num >= {4'b0000, s8_det, 32'h0});
      dv_flg[0].ap_ok <= s8_ap_ok;
    end
  end

  // restoring division, one quotient bit per stage, msb first
  for (genvar g = 0; g < 32; g++) begin : g_div
    localparam int B = 31 - g;
    logic [139:0] trial;
    logic         ge;
    assign trial = {36'h0, dv_den[g]} << B;
    assign ge    = (dv_rem[g] >= trial);
    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem[g+1] <= ge ? (dv_rem[g] - trial) : dv_rem[g];
        dv_q[g+1]   <= {dv_q[g][30:0], ge};
        dv_den[g+1] <= dv_den[g];
        dv_flg[g+1] <= dv_flg[g];
      end
    end
  end

  // valid bits of all stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[NPIPE-2:0], in_pop};
    end
  end

  // final selection and gate decision
  always_comb begin
    fin = dv_flg[32];
    if (fin.sing || (!fin.neg && fin.sat)) begin
      dist_out = '1;
    end else if (fin.neg) begin
      dist_out = '0;
    end else begin
      dist_out = dv_q[32];
    end
    gate = fin.ap_ok && !fin.sing && (dist_out < gate_limit);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vpipe[NPIPE-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {5'b00000, fin.sing, gate, fin.ap_ok, dist_out};
    end
  end

  // checks on the delivered word
  a_sing_sat : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[34] |-> m_tdata[31:0] == 32'hFFFF_FFFF)
    else $error("singular result without saturated distance");

  a_gate_flags : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[33] |-> m_tdata[32] && !m_tdata[34])
    else $error("gate passed with aperture failure or singular sum");

  a_gate_limit : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[33] |-> m_tdata[31:0] < gate_limit)
    else $error("gate passed with distance at or above limit");

endmodule

[rtl/mahalanobis_gate_3d.sv]
// top level of the mahalanobis corner gate with its register port
// One word enters per cycle while the queue is not full. A load word (tuser 0)
// stores the landmark; a test word (tuser 1) yields one result word when the
// stored landmark is a corner, none otherwise. Results leave in order, one per
// cycle at most: the queue hands each test word to the first of nine arithmetic
// stages (angle wrap, adjugate, determinant, quadratic form), then a 32-stage
// restoring divider and the output register follow. A four-word queue between
// front and back lets loads and tests keep arriving while the output side is
// stalled, until it fills. Registers: aperture_threshold at 0x0, gate_limit at
// 0x4; write them only while no test is in flight.
module mahalanobis_gate_3d (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // pos_x, pos_y, heading, aperture, cov_xx, cov_xy, cov_xt, cov_yy, cov_yt,
  // cov_tt, is_corner, zero fill
  input  logic [mg3_pkg::S_DATA_W-1:0] s_tdata,
  // cmd
  input  logic [0:0]                   s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // dist_sq, aperture_ok, in_gate, singular, zero fill
  output logic [mg3_pkg::M_DATA_W-1:0] m_tdata,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import mg3_pkg::*;

  logic [30:0] aperture_threshold;
  logic [31:0] gate_limit;
  logic        cfg_wr;
  cfg_reg_t    reg_sel;

  logic       push, fifo_full, pop, fifo_ne;
  mg3_item_t  push_data, pop_data;

  // register port
  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      aperture_threshold <= 31'd32768;
      gate_limit         <= 32'd1638400;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_APERTURE_THR: aperture_threshold <= pwdata[30:0];
        REG_GATE_LIMIT:   gate_limit         <= pwdata;
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_sel)
      REG_APERTURE_THR: prdata = {1'b0, aperture_threshold};
      REG_GATE_LIMIT:   prdata = gate_limit;
      default:          prdata = '0;
    endcase
  end

  mg3_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .push      (push),
    .push_data (push_data),
    .fifo_full (fifo_full)
  );

  mg3_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (fifo_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (fifo_ne)
  );

  mg3_back u_back (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (fifo_ne),
    .in_data            (pop_data),
    .in_pop             (pop),
    .aperture_threshold (aperture_threshold),
    .gate_limit         (gate_limit),
    .m_tvalid           (m_tvalid),
    .m_tready           (m_tready),
    .m_tdata            (m_tdata)
  );

endmodule
